@@ hw/rtl/tofpp_pkg.sv @@
// ----------------------------------------------------------------------------
// tofpp_pkg
// Shared types, constants and the status code map of the ToF result
// post-processor.
// ----------------------------------------------------------------------------
package tofpp_pkg;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  localparam logic [0:0] RegTargetRate = 1'b0;
  localparam logic [0:0] RegRangeGain  = 1'b1;

  localparam logic [15:0] TargetRateReset = 16'h0A00;
  localparam logic [11:0] RangeGainReset  = 12'd2011;
  localparam logic [28:0] RoundHalf       = 29'h0400;
  localparam int          GainShift       = 11;
  localparam logic [15:0] SpadMidpoint    = 16'h8000;
  localparam logic [15:0] Clip16          = 16'hFFFF;

  localparam int ProdW = 28;

  localparam int RateQuoW         = 32;
  localparam int RateBitsPerStage = 4;
  localparam int RateStages       = RateQuoW / RateBitsPerStage;

  localparam int NeedQuoW         = 16;
  localparam int NeedBitsPerStage = 2;
  localparam int NeedStages       = NeedQuoW / NeedBitsPerStage;

  // raw device status codes
  localparam logic [7:0] DevHwA      = 8'd1;
  localparam logic [7:0] DevHwB      = 8'd2;
  localparam logic [7:0] DevHwC      = 8'd3;
  localparam logic [7:0] DevSignal   = 8'd4;
  localparam logic [7:0] DevBounds   = 8'd5;
  localparam logic [7:0] DevSigma    = 8'd6;
  localparam logic [7:0] DevWrap     = 8'd7;
  localparam logic [7:0] DevMinClip  = 8'd8;
  localparam logic [7:0] DevComplete = 8'd9;
  localparam logic [7:0] DevXtalk    = 8'd12;
  localparam logic [7:0] DevMinRange = 8'd13;
  localparam logic [7:0] DevHwD      = 8'd17;
  localparam logic [7:0] DevSync     = 8'd18;

  typedef enum logic [3:0] {
    RC_VALID    = 4'd0,
    RC_SIGMA    = 4'd1,
    RC_SIGNAL   = 4'd2,
    RC_MINCLIP  = 4'd3,
    RC_BOUNDS   = 4'd4,
    RC_HW       = 4'd5,
    RC_NOWRAP   = 4'd6,
    RC_WRAP     = 4'd7,
    RC_XTALK    = 4'd8,
    RC_SYNC     = 4'd9,
    RC_MINRANGE = 4'd10,
    RC_NONE     = 4'd11
  } range_code_t;

  typedef struct packed {
    logic [7:0]  device_status;
    logic [7:0]  stream_cnt;
    logic [15:0] effective_spads;
    logic [15:0] ambient_rate;
    logic [15:0] raw_range;
    logic [15:0] peak_rate;
  } rec_t;

  typedef struct packed {
    logic [15:0] scaled_range;
    logic [3:0]  range_code;
    logic [15:0] spads_request;
    logic        spads_fallback;
  } res_t;

  typedef struct packed {
    logic [ProdW-1:0] range_prod;
    range_code_t      code;
    logic             spads_zero;
  } side_t;

  typedef struct packed {
    logic zero;
    logic sat;
  } div_flags_t;

  function automatic range_code_t map_status(input logic [7:0] code,
                                             input logic [7:0] streams);
    range_code_t rc;
    unique case (code)
      DevHwA, DevHwB, DevHwC, DevHwD: rc = RC_HW;
      DevSignal:   rc = RC_SIGNAL;
      DevBounds:   rc = RC_BOUNDS;
      DevSigma:    rc = RC_SIGMA;
      DevWrap:     rc = RC_WRAP;
      DevMinClip:  rc = RC_MINCLIP;
      DevComplete: rc = (streams == 8'd0) ? RC_NOWRAP : RC_VALID;
      DevXtalk:    rc = RC_XTALK;
      DevMinRange: rc = RC_MINRANGE;
      DevSync:     rc = RC_SYNC;
      default:     rc = RC_NONE;
    endcase
    return rc;
  endfunction

endpackage

@@ hw/rtl/tofpp_front.sv @@
// ----------------------------------------------------------------------------
// tofpp_front
// Input skid stage, record register, then range product, status map and
// clipped total rate.
// ----------------------------------------------------------------------------
module tofpp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                rec_valid,
  output logic                rec_stall,
  input  tofpp_pkg::rec_t     rec_data,
  input  logic [11:0]         range_gain,
  output logic                b_valid,
  output logic [15:0]         b_total,
  output logic [15:0]         b_spads,
  output tofpp_pkg::side_t    b_side
);

  logic            skid_valid;
  tofpp_pkg::rec_t skid_data;
  logic            src_valid;
  tofpp_pkg::rec_t src_data;
  logic            a_valid;
  tofpp_pkg::rec_t a_data;
  logic [16:0]     sum;

  assign rec_stall = skid_valid;
  assign src_valid = skid_valid | rec_valid;
  assign src_data  = skid_valid ? skid_data : rec_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (rec_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && rec_valid && !skid_valid) begin
      skid_data <= rec_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (en) begin
      a_valid <= src_valid;
      b_valid <= a_valid;
    end
  end

  assign sum = {1'b0, a_data.peak_rate} + {1'b0, a_data.ambient_rate};

  always_ff @(posedge clk) begin
    if (en) begin
      a_data <= src_data;
      b_total <= sum[16] ? tofpp_pkg::Clip16 : sum[15:0];
      b_spads <= a_data.effective_spads;
      b_side.range_prod <= tofpp_pkg::ProdW'(a_data.raw_range)
                           * tofpp_pkg::ProdW'(range_gain);
      b_side.code <= tofpp_pkg::map_status(a_data.device_status, a_data.stream_cnt);
      b_side.spads_zero <= (a_data.effective_spads == 16'd0);
    end
  end

endmodule

@@ hw/rtl/tofpp_rate_div.sv @@
// ----------------------------------------------------------------------------
// tofpp_rate_div
// Pipelined restoring divider: (total << 16) / spads, a few quotient bits
// per stage.
// ----------------------------------------------------------------------------
module tofpp_rate_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            src_valid,
  input  logic [15:0]                     src_total,
  input  logic [15:0]                     src_spads,
  input  tofpp_pkg::side_t                src_side,
  output logic                            dst_valid,
  output logic [tofpp_pkg::RateQuoW-1:0]  dst_quo,
  output tofpp_pkg::side_t                dst_side
);

  localparam int N = tofpp_pkg::RateStages;
  localparam int QW = tofpp_pkg::RateQuoW;

  logic             v    [N];
  logic [QW-1:0]    dvd  [N];
  logic [QW-1:0]    quo  [N];
  logic [15:0]      rem  [N];
  logic [15:0]      dsr  [N];
  tofpp_pkg::side_t side [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic             v_in;
    logic [QW-1:0]    dvd_in;
    logic [QW-1:0]    quo_in;
    logic [15:0]      rem_in;
    logic [15:0]      dsr_in;
    tofpp_pkg::side_t side_in;
    logic [QW-1:0]    dvd_nx;
    logic [QW-1:0]    quo_nx;
    logic [15:0]      rem_nx;

    if (s == 0) begin : g_first
      assign v_in    = src_valid;
      assign dvd_in  = {src_total, 16'd0};
      assign quo_in  = '0;
      assign rem_in  = '0;
      assign dsr_in  = src_spads;
      assign side_in = src_side;
    end else begin : g_next
      assign v_in    = v[s-1];
      assign dvd_in  = dvd[s-1];
      assign quo_in  = quo[s-1];
      assign rem_in  = rem[s-1];
      assign dsr_in  = dsr[s-1];
      assign side_in = side[s-1];
    end

    always_comb begin
      logic [16:0] t;
      dvd_nx = dvd_in;
      quo_nx = quo_in;
      rem_nx = rem_in;
      for (int k = 0; k < tofpp_pkg::RateBitsPerStage; k++) begin
        t = {rem_nx, dvd_nx[QW-1]};
        dvd_nx = {dvd_nx[QW-2:0], 1'b0};
        if (t >= {1'b0, dsr_in}) begin
          t = t - {1'b0, dsr_in};
          quo_nx = {quo_nx[QW-2:0], 1'b1};
        end else begin
          quo_nx = {quo_nx[QW-2:0], 1'b0};
        end
        rem_nx = t[15:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en) begin
        v[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dvd[s]  <= dvd_nx;
        quo[s]  <= quo_nx;
        rem[s]  <= rem_nx;
        dsr[s]  <= dsr_in;
        side[s] <= side_in;
      end
    end
  end

  assign dst_valid = v[N-1];
  assign dst_quo   = quo[N-1];
  assign dst_side  = side[N-1];

endmodule

@@ hw/rtl/tofpp_need_div.sv @@
// ----------------------------------------------------------------------------
// tofpp_need_div
// Required SPAD count: (target << 16) / per_spad with saturation and
// zero-divisor detection up front, then a pipelined 16-bit quotient.
// ----------------------------------------------------------------------------
module tofpp_need_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic [15:0]                     target_rate,
  input  logic                            src_valid,
  input  logic [tofpp_pkg::RateQuoW-1:0]  src_per_spad,
  input  tofpp_pkg::side_t                src_side,
  output logic                            dst_valid,
  output logic [tofpp_pkg::NeedQuoW-1:0]  dst_quo,
  output tofpp_pkg::div_flags_t           dst_flags,
  output tofpp_pkg::side_t                dst_side
);

  localparam int N  = tofpp_pkg::NeedStages;
  localparam int DW = tofpp_pkg::RateQuoW;
  localparam int QW = tofpp_pkg::NeedQuoW;

  logic                  v     [N+1];
  logic [QW-1:0]         quo   [N+1];
  logic [DW-1:0]         rem   [N+1];
  logic [DW-1:0]         dsr   [N+1];
  tofpp_pkg::div_flags_t flags [N+1];
  tofpp_pkg::side_t      side  [N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= src_valid;
    end
  end

  // quotient reaches 2^16 exactly when target >= per_spad
  always_ff @(posedge clk) begin
    if (en) begin
      quo[0]       <= '0;
      rem[0]       <= DW'(target_rate);
      dsr[0]       <= src_per_spad;
      flags[0].zero <= src_side.spads_zero || (src_per_spad == '0);
      flags[0].sat  <= (DW'(target_rate) >= src_per_spad);
      side[0]      <= src_side;
    end
  end

  for (genvar s = 1; s <= N; s++) begin : g_stage
    logic [QW-1:0] quo_nx;
    logic [DW-1:0] rem_nx;

    always_comb begin
      logic [DW:0] t;
      quo_nx = quo[s-1];
      rem_nx = rem[s-1];
      for (int k = 0; k < tofpp_pkg::NeedBitsPerStage; k++) begin
        t = {rem_nx, 1'b0};
        if (t >= {1'b0, dsr[s-1]}) begin
          t = t - {1'b0, dsr[s-1]};
          quo_nx = {quo_nx[QW-2:0], 1'b1};
        end else begin
          quo_nx = {quo_nx[QW-2:0], 1'b0};
        end
        rem_nx = t[DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en) begin
        v[s] <= v[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo[s]   <= quo_nx;
        rem[s]   <= rem_nx;
        dsr[s]   <= dsr[s-1];
        flags[s] <= flags[s-1];
        side[s]  <= side[s-1];
      end
    end
  end

  assign dst_valid = v[N];
  assign dst_quo   = quo[N];
  assign dst_flags = flags[N];
  assign dst_side  = side[N];

endmodule

@@ hw/rtl/tof_result_post_processor_core.sv @@
// ----------------------------------------------------------------------------
// tof_result_post_processor_core
// ToF ranging result post-processor: gain-corrected range, dense status
// code and next SPAD count request from one raw result record.
// ----------------------------------------------------------------------------
// Usage:
//   rec channel: one raw result record per transfer (rec_valid/rec_stall).
//   res channel: one result per record, in order (res_valid/res_stall).
//   APB port: target_rate at 0x0, range_gain at 0x4; write only while idle.
// Throughput: one record per cycle while res is not stalled.
// The pipeline is 20 register stages:
//   two front stages, an 8-stage divider for the rate per SPAD (4 quotient
//   bits a stage), a check stage plus an 8-stage divider for the SPAD count
//   (2 quotient bits a stage), and the output register.
// Stall: while res is stalled with a result waiting, the whole pipeline
//   holds; one more record is taken into a skid register, then rec_stall
//   rises until res moves again.
// Reset: clears all valid bits, the skid valid bit too; target_rate returns
//   to 0x0A00 and range_gain to 2011.
// ----------------------------------------------------------------------------
module tof_result_post_processor_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tofpp_pkg::CfgAddrW-1:0]    paddr,
  input  logic [tofpp_pkg::CfgDataW-1:0]    pwdata,
  output logic [tofpp_pkg::CfgDataW-1:0]    prdata,
  output logic                              pready,
  input  logic                              rec_valid,
  output logic                              rec_stall,
  input  tofpp_pkg::rec_t                   rec_data,
  output logic                              res_valid,
  input  logic                              res_stall,
  output tofpp_pkg::res_t                   res_data
);

  logic [15:0]                    target_rate;
  logic [11:0]                    range_gain;
  logic                           en;
  logic                           b_valid;
  logic [15:0]                    b_total;
  logic [15:0]                    b_spads;
  tofpp_pkg::side_t               b_side;
  logic                           r_valid;
  logic [tofpp_pkg::RateQuoW-1:0] r_quo;
  tofpp_pkg::side_t               r_side;
  logic                           n_valid;
  logic [tofpp_pkg::NeedQuoW-1:0] n_quo;
  tofpp_pkg::div_flags_t          n_flags;
  tofpp_pkg::side_t               n_side;
  logic [28:0]                    rsum;
  logic [17:0]                    rscaled;
  logic [15:0]                    request;
  logic                           out_valid;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_rate <= tofpp_pkg::TargetRateReset;
      range_gain  <= tofpp_pkg::RangeGainReset;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        tofpp_pkg::RegTargetRate: target_rate <= pwdata[15:0];
        tofpp_pkg::RegRangeGain:  range_gain  <= pwdata[11:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tofpp_pkg::RegTargetRate: prdata = {16'd0, target_rate};
      tofpp_pkg::RegRangeGain:  prdata = {20'd0, range_gain};
    endcase
  end

  assign en = !(out_valid && res_stall);

  tofpp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .rec_valid  (rec_valid),
    .rec_stall  (rec_stall),
    .rec_data   (rec_data),
    .range_gain (range_gain),
    .b_valid    (b_valid),
    .b_total    (b_total),
    .b_spads    (b_spads),
    .b_side     (b_side)
  );

  tofpp_rate_div u_rate_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .src_valid (b_valid),
    .src_total (b_total),
    .src_spads (b_spads),
    .src_side  (b_side),
    .dst_valid (r_valid),
    .dst_quo   (r_quo),
    .dst_side  (r_side)
  );

  tofpp_need_div u_need_div (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .target_rate  (target_rate),
    .src_valid    (r_valid),
    .src_per_spad (r_quo),
    .src_side     (r_side),
    .dst_valid    (n_valid),
    .dst_quo      (n_quo),
    .dst_flags    (n_flags),
    .dst_side     (n_side)
  );

  assign rsum    = 29'(n_side.range_prod) + tofpp_pkg::RoundHalf;
  assign rscaled = rsum[28:tofpp_pkg::GainShift];

  always_comb begin
    priority if (n_flags.zero) begin
      request = tofpp_pkg::SpadMidpoint;
    end else if (n_flags.sat) begin
      request = tofpp_pkg::Clip16;
    end else begin
      request = n_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= n_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_data.scaled_range   <= (rscaled[17:16] != 2'd0) ? tofpp_pkg::Clip16
                                                          : rscaled[15:0];
      res_data.range_code     <= n_side.code;
      res_data.spads_request  <= request;
      res_data.spads_fallback <= n_flags.zero;
    end
  end

  assign res_valid = out_valid;

endmodule

@@ hw/rtl/tofpp_check.sv @@
// ----------------------------------------------------------------------------
// tofpp_check
// Port-level assertions for the ToF result post-processor, bound to the
// top level.
// ----------------------------------------------------------------------------
module tofpp_check (
  input logic            clk,
  input logic            rst,
  input logic            rec_stall,
  input logic            res_valid,
  input logic            res_stall,
  input tofpp_pkg::res_t res_data
);

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled result transfer changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(rec_stall) |-> $past(res_valid && res_stall))
    else $error("rec_stall rose without a stalled result");

  a_fallback_mid: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.spads_fallback |->
      res_data.spads_request == tofpp_pkg::SpadMidpoint)
    else $error("fallback without midpoint request");

endmodule

bind tof_result_post_processor_core tofpp_check u_check (
  .clk       (clk),
  .rst       (rst),
  .rec_stall (rec_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);

@@ test/tb_tof_result_post_processor_core.sv @@
// ----------------------------------------------------------------------------
// tb_tof_result_post_processor_core
// Self-checking bench for the ToF result post-processor. Directed records
// sweep every device status code and the range and SPAD request corner
// cases. Random records then run under several target rate and range gain
// settings, with random gaps on the rec channel and random stalls on the res
// channel. Each result is checked field by field against its directed row or a model.
// ----------------------------------------------------------------------------
module tb_tof_result_post_processor_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tofpp_pkg::*;

  localparam int CycleLimit  = 100000;
  localparam int DrainCycles = 25;
  localparam int NumDir      = 22;
  localparam int PhaseItems  = 90;
  localparam int NumPhases   = 7;

  localparam logic [CfgAddrW-1:0] TargetAddr = {RegTargetRate, 2'b00};
  localparam logic [CfgAddrW-1:0] GainAddr   = {RegRangeGain, 2'b00};

  typedef struct packed {
    rec_t rec;
    logic known;
    res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic pready;
  logic rec_valid = 1'b0;
  logic rec_stall;
  rec_t rec_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res_data;

  logic [15:0] target_q = TargetRateReset;
  logic [11:0] gain_q = RangeGainReset;
  logic gaps_on = 1'b1;
  res_t pending_results[$];
  int fail_count = 0;
  int cycle_count = 0;

  // range 0 and SPAD count 0 give scaled_range 0 and the 0x8000 fallback
  dir_row_t dir_rows [NumDir] = '{
    '{'{8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{16'd0, RC_NONE, SpadMidpoint, 1'b1}},
    '{'{DevHwA, 8'd3, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{16'd0, RC_HW, SpadMidpoint, 1'b1}},
    '{'{DevHwB, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{16'd0, RC_HW, SpadMidpoint, 1'b1}},
    '{'{DevHwC, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{16'd0, RC_HW, SpadMidpoint, 1'b1}},
    '{'{DevHwD, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{16'd0, RC_HW, SpadMidpoint, 1'b1}},
    '{'{DevSignal, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{16'd0, RC_SIGNAL, SpadMidpoint, 1'b1}},
    '{'{DevBounds, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{16'd0, RC_BOUNDS, SpadMidpoint, 1'b1}},
    '{'{DevSigma, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{16'd0, RC_SIGMA, SpadMidpoint, 1'b1}},
    '{'{DevWrap, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{16'd0, RC_WRAP, SpadMidpoint, 1'b1}},
    '{'{DevMinClip, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{16'd0, RC_MINCLIP, SpadMidpoint, 1'b1}},
    '{'{DevComplete, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{16'd0, RC_NOWRAP, SpadMidpoint, 1'b1}},
    '{'{DevComplete, 8'hFF, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{16'd0, RC_VALID, SpadMidpoint, 1'b1}},
    '{'{DevXtalk, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{16'd0, RC_XTALK, SpadMidpoint, 1'b1}},
    '{'{DevMinRange, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{16'd0, RC_MINRANGE, SpadMidpoint, 1'b1}},
    '{'{DevSync, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{16'd0, RC_SYNC, SpadMidpoint, 1'b1}},
    '{'{8'd10, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{16'd0, RC_NONE, SpadMidpoint, 1'b1}},
    '{'{8'hFF, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{16'd0, RC_NONE, SpadMidpoint, 1'b1}},
    // zero total rate: fallback with a nonzero SPAD count
    '{'{DevComplete, 8'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{16'd0, RC_VALID, SpadMidpoint, 1'b1}},
    // rate per SPAD of 1: request clips
    '{'{8'd0, 8'd0, 16'hFFFF, 16'd0, 16'd0, 16'd1}, 1'b1,
      '{16'd0, RC_NONE, Clip16, 1'b0}},
    '{'{8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
    '{'{DevSignal, 8'd2, 16'd1, 16'hFFFF, 16'h8000, 16'hFFFF}, 1'b0, '0},
    '{'{DevComplete, 8'd7, 16'h0100, 16'h0080, 16'd1, 16'h0080}, 1'b0, '0}
  };

  tof_result_post_processor_core dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec_data  (rec_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic res_t predict_record(rec_t r);
    logic [28:0] prod;
    logic [17:0] scaled;
    logic [16:0] total;
    logic [31:0] per_spad;
    logic [31:0] need;
    res_t o;
    prod = r.raw_range * gain_q + RoundHalf;
    scaled = prod[28:GainShift];
    o.scaled_range = (scaled > 18'h0FFFF) ? Clip16 : scaled[15:0];
    case (r.device_status)
      DevHwA, DevHwB, DevHwC, DevHwD: o.range_code = RC_HW;
      DevSignal:   o.range_code = RC_SIGNAL;
      DevBounds:   o.range_code = RC_BOUNDS;
      DevSigma:    o.range_code = RC_SIGMA;
      DevWrap:     o.range_code = RC_WRAP;
      DevMinClip:  o.range_code = RC_MINCLIP;
      DevComplete: o.range_code = (r.stream_cnt == 8'd0) ? RC_NOWRAP : RC_VALID;
      DevXtalk:    o.range_code = RC_XTALK;
      DevMinRange: o.range_code = RC_MINRANGE;
      DevSync:     o.range_code = RC_SYNC;
      default:     o.range_code = RC_NONE;
    endcase
    o.spads_request = SpadMidpoint;
    o.spads_fallback = 1'b1;
    if (r.effective_spads != 16'd0) begin
      total = r.peak_rate + r.ambient_rate;
      if (total > 17'h0FFFF) total = 17'h0FFFF;
      per_spad = {total[15:0], 16'h0000} / r.effective_spads;
      if (per_spad != 32'd0) begin
        need = {target_q, 16'h0000} / per_spad;
        o.spads_request = (need > 32'h0000FFFF) ? Clip16 : need[15:0];
        o.spads_fallback = 1'b0;
      end
    end
    return o;
  endfunction

  function automatic rec_t random_record();
    rec_t r;
    int pick;
    r.device_status = ($urandom_range(9) < 8) ? 8'($urandom_range(19)) : 8'($urandom);
    r.stream_cnt = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom);
    pick = $urandom_range(9);
    if (pick == 0) r.effective_spads = 16'd0;
    else if (pick == 1) r.effective_spads = 16'hFFFF;
    else if (pick < 5) r.effective_spads = 16'($urandom_range(1, 256));
    else r.effective_spads = 16'($urandom);
    pick = $urandom_range(9);
    if (pick == 0) begin
      r.peak_rate = 16'd0;
      r.ambient_rate = 16'd0;
    end else if (pick < 3) begin
      r.peak_rate = 16'($urandom_range(15));
      r.ambient_rate = 16'($urandom_range(15));
    end else begin
      r.peak_rate = 16'($urandom);
      r.ambient_rate = 16'($urandom);
    end
    r.raw_range = 16'($urandom);
    return r;
  endfunction

  task automatic send_rec(rec_t r, res_t exp_res);
    while (gaps_on && $urandom_range(99) < 9) begin
      rec_valid <= 1'b0;
      @(negedge clk);
    end
    rec_valid <= 1'b1;
    rec_data <= r;
    do @(posedge clk); while (rec_stall !== 1'b0);
    pending_results.push_back(exp_res);
    @(negedge clk);
  endtask

  task automatic apb_access(logic [CfgAddrW-1:0] addr, logic wr, logic [CfgDataW-1:0] wdata,
                            output logic [CfgDataW-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] exp_val);
    logic [CfgDataW-1:0] got;
    apb_access(addr, 1'b0, '0, got);
    if (got !== exp_val) begin
      $display("%0t: register 0x%0h expected %h actual %h", $time, addr, exp_val, got);
      fail_count++;
    end
  endtask

  task automatic program_regs(logic [15:0] target, logic [11:0] gain);
    logic [CfgDataW-1:0] unused;
    apb_access(TargetAddr, 1'b1, ($urandom & 32'hFFFF0000) | target, unused);
    apb_access(GainAddr, 1'b1, ($urandom & 32'hFFFFF000) | gain, unused);
    target_q = target;
    gain_q = gain;
    check_reg(TargetAddr, {16'd0, target});
    check_reg(GainAddr, {20'd0, gain});
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  always @(negedge clk) begin
    res_stall <= !rst && gaps_on && ($urandom_range(99) < 9);
  end

  always @(posedge clk) begin
    res_t exp_res;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none pending, actual %p", $time, res_data);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (res_data.scaled_range !== exp_res.scaled_range) begin
          $display("%0t: scaled_range expected %h actual %h", $time,
                   exp_res.scaled_range, res_data.scaled_range);
          fail_count++;
        end
        if (res_data.range_code !== exp_res.range_code) begin
          $display("%0t: range_code expected %0d actual %0d", $time,
                   exp_res.range_code, res_data.range_code);
          fail_count++;
        end
        if (res_data.spads_request !== exp_res.spads_request) begin
          $display("%0t: spads_request expected %h actual %h", $time,
                   exp_res.spads_request, res_data.spads_request);
          fail_count++;
        end
        if (res_data.spads_fallback !== exp_res.spads_fallback) begin
          $display("%0t: spads_fallback expected %b actual %b", $time,
                   exp_res.spads_fallback, res_data.spads_fallback);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rec_t r;
    logic [15:0] target;
    logic [11:0] gain;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    check_reg(TargetAddr, {16'd0, TargetRateReset});
    check_reg(GainAddr, {20'd0, RangeGainReset});
    for (int i = 0; i < NumDir; i++) begin
      send_rec(dir_rows[i].rec,
               dir_rows[i].known ? dir_rows[i].res : predict_record(dir_rows[i].rec));
    end
    for (int p = 0; p < NumPhases; p++) begin
      rec_valid <= 1'b0;
      drain();
      case (p)
        0: begin
          target = 16'h0000;
          gain = 12'd0;
        end
        1: begin
          target = 16'hFFFF;
          gain = 12'd2048;
        end
        2: begin
          target = 16'hFFFF;
          gain = 12'hFFF;
        end
        3: begin
          target = 16'h0001;
          gain = 12'd1;
        end
        default: begin
          target = 16'($urandom);
          gain = ($urandom_range(3) == 0) ? 12'($urandom_range(2049, 4095))
                                          : 12'($urandom_range(0, 2048));
        end
      endcase
      program_regs(target, gain);
      // one phase runs with no gaps or stalls at all
      gaps_on = (p != 2);
      repeat (PhaseItems) begin
        r = random_record();
        send_rec(r, predict_record(r));
      end
    end
    rec_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/tofpp_pkg.sv
hw/rtl/tofpp_front.sv
hw/rtl/tofpp_rate_div.sv
hw/rtl/tofpp_need_div.sv
hw/rtl/tof_result_post_processor_core.sv
hw/rtl/tofpp_check.sv
test/tb_tof_result_post_processor_core.sv
